/* hdl/sobel_pkg.sv */
// Shared types and constants for the RGB Sobel edge magnitude block.
// No dependencies; imported by the controller, the datapath and the top level.
package sobel_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int CFG_DATA_W     = 11;
    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       end_of_row;
        logic       end_of_frame;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic shift;
        logic grad;
        logic square;
        logic sum;
        logic root_init;
        logic root_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic produce;
        logic root_last;
        logic out_free;
    } t_ctrl_status;

endpackage

/* hdl/sobel_edge_magnitude_rgb.sv */
// Top level of the streaming RGB Sobel edge magnitude block.
// Depends on sobel_pkg, sobel_ctrl and sobel_dp.
//
//  Channel   Signals                               Direction
//  input     i_in_valid / o_in_ready / i_in_data   pixels or drain steps in
//  output    o_out_valid / i_out_ready / o_out_data edge magnitudes out
//  config    i_cfg_we / i_cfg_index / i_cfg_data   frame width and height
//
// An item that yields no result passes the idle and shift states; one that yields a
// result goes on through the gradient, square, sum, bit-serial root and emit states.
// The result waits in an output register, so the next transfer can start while
// it is pending; a second result stalls in the final state until that register frees.
// Reset is synchronous and active low; any register write restarts the frame.
module sobel_edge_magnitude_rgb
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sobel_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/sobel_ctrl.sv */
// Sequencing state machine for the Sobel block.
// Depends on sobel_pkg for the state type and the command/status structs.
module sobel_ctrl
    import sobel_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.produce ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum       = 1'b1;
                o_cmd.root_init = 1'b1;
                n_state         = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/sobel_dp.sv */
// Datapath of the Sobel block: row stores, 3x3 window, counters, gradients,
// bit-serial rounded square root and the output register. Depends on sobel_pkg.
module sobel_dp
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_status          o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_TOP = 2 * MAX_HEIGHT + 2;
    localparam int RW      = $clog2(ROW_TOP + 1);
    localparam int W_RST   = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int H_RST   = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;

    logic [23:0] r_mem_up [MAX_WIDTH];
    logic [23:0] r_mem_lo [MAX_WIDTH];
    logic [23:0] r_up_q;
    logic [23:0] r_lo_q;
    logic [23:0] r_px;
    logic [23:0] r_win [9];

    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [HW-1:0] r_out_row;

    logic signed [11:0] r_gx [3];
    logic signed [11:0] r_gy [3];
    logic [19:0]        r_sqx [3];
    logic [19:0]        r_sqy [3];
    logic [20:0]        r_s [3];
    logic [7:0]         r_n [3];
    logic [2:0]         r_bit;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               col_last;
    logic               out_eor;
    logic               out_eof;
    logic               restart;
    logic [8:0]         tap_ok;
    logic signed [11:0] n_gx [3];
    logic signed [11:0] n_gy [3];
    logic [7:0]         n_n [3];
    logic [WW-1:0]      cfg_w;
    logic [HW-1:0]      cfg_h;

    // Register writes are clamped into the legal frame size range.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w = WW'(1);
            cfg_h = HW'(1);
        end else begin
            cfg_w = (32'(i_cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(i_cfg_data);
            cfg_h = (32'(i_cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
    end

    assign col_last = (32'(r_in_col) + 1) >= 32'(r_width);
    assign out_eor  = (32'(r_out_col) + 1) >= 32'(r_width);
    assign out_eof  = out_eor && ((32'(r_out_row) + 1) >= 32'(r_height));
    assign restart  = i_cfg_we || (i_cmd.load_out && out_eof);

    assign o_status.produce   = (r_in_row >= RW'(2)) ||
                                (r_in_row == RW'(1) && r_in_col != '0);
    assign o_status.root_last = (r_bit == 3'd0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RST);
            r_height <= HW'(H_RST);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_width <= cfg_w;
            end else begin
                r_height <= cfg_h;
            end
        end
    end

    // Row stores: read on capture, written back while the window shifts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_up_q <= r_mem_up[r_in_col];
            r_lo_q <= r_mem_lo[r_in_col];
            r_px   <= (i_in_data.command == CMD_PIXEL) ?
                      {i_in_data.pixel_red, i_in_data.pixel_green, i_in_data.pixel_blue} :
                      24'd0;
        end
        if (i_cmd.shift) begin
            r_mem_up[r_in_col] <= r_lo_q;
            r_mem_lo[r_in_col] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (i_cmd.shift) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]     <= r_win[r*3+1];
                    r_win[r*3 + 1] <= r_win[r*3+2];
                end
                r_win[2] <= r_up_q;
                r_win[5] <= r_lo_q;
                r_win[8] <= r_px;
                if (col_last) begin
                    r_in_col <= '0;
                    if (32'(r_in_row) < ROW_TOP) begin
                        r_in_row <= r_in_row + RW'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                if (out_eor) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + HW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // Taps outside the frame read as black.
    always_comb begin
        logic row_ok [3];
        logic col_ok [3];
        row_ok[0] = (r_out_row != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = !((32'(r_out_row) + 1) >= 32'(r_height));
        col_ok[0] = (r_out_col != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = !out_eor;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                tap_ok[r*3 + c] = row_ok[r] && col_ok[c];
            end
        end
    end

    always_comb begin
        logic [9:0] t [9];
        logic [9:0] xp, xn, yp, yn;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) begin
                t[i] = tap_ok[i] ? {2'b00, r_win[i][8*(2-k) +: 8]} : 10'd0;
            end
            xp = t[2] + (t[5] << 1) + t[8];
            xn = t[0] + (t[3] << 1) + t[6];
            yp = t[6] + (t[7] << 1) + t[8];
            yn = t[0] + (t[1] << 1) + t[2];
            n_gx[k] = $signed({2'b00, xp}) - $signed({2'b00, xn});
            n_gy[k] = $signed({2'b00, yp}) - $signed({2'b00, yn});
        end
    end

    // One result bit per cycle: keep the candidate when c*c - c is below the sum.
    always_comb begin
        logic [7:0]  cand;
        logic [15:0] f;
        for (int k = 0; k < 3; k++) begin
            cand   = r_n[k] | (8'd1 << r_bit);
            f      = ({8'd0, cand} * {8'd0, cand}) - {8'd0, cand};
            n_n[k] = ({5'd0, f} < r_s[k]) ? cand : r_n[k];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [23:0] px2, py2;
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.grad) begin
                r_gx[k] <= n_gx[k];
                r_gy[k] <= n_gy[k];
            end
            if (i_cmd.square) begin
                px2      = r_gx[k] * r_gx[k];
                py2      = r_gy[k] * r_gy[k];
                r_sqx[k] <= px2[19:0];
                r_sqy[k] <= py2[19:0];
            end
            if (i_cmd.sum) begin
                r_s[k] <= {1'b0, r_sqx[k]} + {1'b0, r_sqy[k]};
            end
            if (i_cmd.root_init) begin
                r_n[k] <= '0;
            end else if (i_cmd.root_step) begin
                r_n[k] <= n_n[k];
            end
        end
        if (i_cmd.root_init) begin
            r_bit <= 3'd7;
        end else if (i_cmd.root_step) begin
            r_bit <= r_bit - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.edge_red     <= r_n[0];
            r_out.edge_green   <= r_n[1];
            r_out.edge_blue    <= r_n[2];
            r_out.end_of_row   <= out_eor;
            r_out.end_of_frame <= out_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* dv/sobel_checker.sv */
`timescale 1ns / 100ps
// Watches the pixel, result and register ports of the RGB Sobel block, predicts
// each result and compares it field by field. Depends on sobel_pkg only.
module sobel_checker
    import sobel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results
);

    localparam int KX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int KY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    int          width_eff;
    int          height_eff;
    logic [23:0] line_upper [DEF_MAX_WIDTH];
    logic [23:0] line_lower [DEF_MAX_WIDTH];
    logic [23:0] win [9];
    int          in_col, in_row, out_col, out_row;
    t_out_item   edge_queue [$];

    assign o_pending = edge_queue.size();

    function automatic logic [7:0] rounded_root(int s);
        int n;
        n = 0;
        while (n < 255 && (n + 1) * n < s) n++;
        return n[7:0];
    endfunction

    function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return int'(v);
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic advance_window(t_in_item it);
        logic [23:0] px;
        int          idx;
        bit          produce;
        bit          tap_ok [9];
        bit          row_ok, col_ok, eor, eof;
        int          gx, gy, v, sh;
        logic [7:0]  mag [3];
        t_out_item   res;

        px  = (it.command == CMD_PIXEL) ?
              {it.pixel_red, it.pixel_green, it.pixel_blue} : 24'h0;
        idx = (in_col < DEF_MAX_WIDTH) ? in_col : 0;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = line_upper[idx];
        win[5] = line_lower[idx];
        win[8] = px;
        line_upper[idx] = line_lower[idx];
        line_lower[idx] = px;

        produce = in_row >= 2 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= width_eff) begin
            in_col = 0;
            if (in_row < 2 * DEF_MAX_HEIGHT + 2) in_row++;
        end
        if (!produce) return;

        // Taps that fall outside the frame read as black.
        for (int r = 0; r < 3; r++) begin
            row_ok = !((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= height_eff));
            for (int c = 0; c < 3; c++) begin
                col_ok = !((c == 0 && out_col == 0) ||
                           (c == 2 && out_col + 1 >= width_eff));
                tap_ok[r*3+c] = row_ok && col_ok;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            sh = 16 - 8 * ch;
            gx = 0;
            gy = 0;
            for (int i = 0; i < 9; i++) begin
                if (tap_ok[i]) begin
                    v  = int'((win[i] >> sh) & 24'hFF);
                    gx += v * KX[i];
                    gy += v * KY[i];
                end
            end
            mag[ch] = rounded_root(gx * gx + gy * gy);
        end
        eor = out_col + 1 >= width_eff;
        eof = eor && out_row + 1 >= height_eff;
        res.edge_red     = mag[0];
        res.edge_green   = mag[1];
        res.edge_blue    = mag[2];
        res.end_of_row   = eor;
        res.end_of_frame = eof;
        edge_queue.push_back(res);

        if (eof) begin
            restart_frame();
        end else if (eor) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            width_eff    = RST_WIDTH;
            height_eff   = RST_HEIGHT;
            o_fail_count = 0;
            o_results    = 0;
            edge_queue.delete();
            for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
                line_upper[i] = '0;
                line_lower[i] = '0;
            end
            restart_frame();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (edge_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with nothing expected: %p", $realtime, i_out_data);
                end else begin
                    want = edge_queue.pop_front();
                    if (i_out_data !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch, expected %p got %p",
                                     $realtime, want, i_out_data);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH)
                    width_eff = clamp_dim(i_cfg_data, DEF_MAX_WIDTH);
                else
                    height_eff = clamp_dim(i_cfg_data, DEF_MAX_HEIGHT);
                restart_frame();
            end
            if (i_in_valid && i_in_ready) advance_window(i_in_data);
        end
    end

endmodule

/* dv/tb_sobel_edge_magnitude_rgb.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for the RGB Sobel edge magnitude block: frames of many
// sizes, drains and broken sequences. Depends on sobel_pkg and sobel_checker.
module tb_sobel_edge_magnitude_rgb
    import sobel_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    int fail_count, pending, results;
    int idle_mode = 0;      // 0: sender light, receiver heavy; 1: swapped; 2: none
    int hold_cycles = 0;
    int cycle_count = 0;
    int frames_done = 0;
    int random_items = 0;
    bit long_hold_done = 1'b0;

    always #5 i_clk = ~i_clk;

    sobel_edge_magnitude_rgb dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data
    );

    sobel_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sobel_edge_magnitude_rgb regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready = 1'b0;
        end else if (idle_mode == 0) begin
            i_out_ready = ($urandom_range(99) >= 62);
        end else if (idle_mode == 1) begin
            i_out_ready = ($urandom_range(99) >= 21);
        end else begin
            i_out_ready = 1'b1;
        end
    end

    task automatic send_item(logic cmd, logic [23:0] rgb);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 21 : (idle_mode == 1) ? 62 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = {cmd, rgb};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [23:0] pick_pixel(int style);
        case (style)
            0:       return 24'($urandom);
            1:       return {$urandom_range(1) ? 8'hFF : 8'h00,
                             $urandom_range(1) ? 8'hFF : 8'h00,
                             $urandom_range(1) ? 8'hFF : 8'h00};
            2:       return 24'hFFFFFF;
            default: return 24'h000000;
        endcase
    endfunction

    // One frame of w*h positions then w+1 drains. noise_pct swaps the command
    // of a position: black stand-ins inside the frame, pixels among the drains.
    task automatic run_frame(int w, int h, int style, int noise_pct);
        logic cmd;
        for (int i = 0; i < w * h + w + 1; i++) begin
            cmd = (i < w * h) ? CMD_PIXEL : CMD_DRAIN;
            if ($urandom_range(99) < noise_pct) cmd = ~cmd;
            send_item(cmd, pick_pixel(style));
            random_items++;
        end
        frames_done++;
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    initial begin
        int w, h;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: partial frame at reset size, then aborted by a write.
        for (int i = 0; i < 5; i++) send_item(CMD_PIXEL, 24'($urandom));
        set_size(3, 3);
        run_frame(3, 3, 2, 0);
        set_size(0, 0);                       // both clamp to one
        run_frame(1, 1, 0, 0);
        write_reg(REG_FRAME_WIDTH, '1);        // above the maximum, clamps
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        for (int i = 0; i < 3; i++) send_item(CMD_DRAIN, 24'hFFFFFF);
        set_size(4, 2);
        send_item(CMD_PIXEL, 24'hFFFFFF);
        send_item(CMD_DRAIN, 24'hA5A5A5);      // black stand-in inside the frame
        for (int i = 0; i < 6; i++) send_item(CMD_PIXEL, 24'h00FF00);
        send_item(CMD_PIXEL, 24'h123456);      // pixel where a drain is due
        for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 24'h0);

        // Random frames, mostly well formed and small.
        random_items = 0;
        while (random_items < 450) begin
            idle_mode = (random_items < 150) ? 0 : (random_items < 300) ? 1 : 2;
            w = $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            set_size(w, h);
            // The receiver stalls while the frame is offered, so the input backs up.
            if (!long_hold_done && random_items > 60 && idle_mode == 0) begin
                hold_cycles    = 400;
                long_hold_done = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                // Abandoned frame: cut short and restarted by the next write.
                for (int i = 0; i < $urandom_range(w * h, 1); i++) begin
                    send_item(CMD_PIXEL, 24'($urandom));
                    random_items++;
                end
            end else begin
                run_frame(w, h, $urandom_range(3), ($urandom_range(3) == 0) ? 8 : 0);
            end
        end

        // Largest sizes: part of a full-width row, then a one-pixel-wide column.
        idle_mode = 2;
        set_size(1024, 2);
        for (int i = 0; i < 24; i++) send_item(CMD_PIXEL, 24'($urandom));
        set_size(1, 1024);
        for (int i = 0; i < 24; i++) send_item(CMD_PIXEL, 24'($urandom));

        wait_idle();
        $display("Covered %0d frames up to 8x6 and partial frames at the largest sizes, %0d results.",
                 frames_done, results);
        $display("Drains inside frames, pixels among drains and aborted frames included.");
        if (fail_count == 0) begin
            $display("sobel_edge_magnitude_rgb regression: pass");
        end else begin
            $display("sobel_edge_magnitude_rgb regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/sobel_pkg.sv
hdl/sobel_ctrl.sv
hdl/sobel_dp.sv
hdl/sobel_edge_magnitude_rgb.sv
dv/sobel_checker.sv
dv/tb_sobel_edge_magnitude_rgb.sv
